FILE: src/mqf_pkg.sv
// Shared types and constants for the moving quantile filter.
`default_nettype none

package mqf_pkg;

    // Quantile is unsigned Q16: 65536 stands for 1.0
    localparam int QFRAC_BITS = 16;
    localparam int QF_BITS    = QFRAC_BITS + 1;
    localparam logic [QF_BITS-1:0] Q_ONE = QF_BITS'(1) << QFRAC_BITS;

    // Width of the window length register
    localparam int WLEN_BITS = 7;

    // Register indexes (paddr[2])
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_QUANTILE_FRAC = 1'b1;

    // Command to the sorted-store update pass
    typedef struct packed {
        logic start;    // launch a pass this cycle
        logic descend;  // walk from the top entry downward
        logic seek;     // find and drop the evicted value before shifting
    } mqf_pass_ctl_t;

endpackage

`default_nettype wire

FILE: src/moving_quantile_filter.sv
// Top level of the moving quantile filter: ring buffer, sequencer, multiplier, APB registers.
`default_nettype none

// Running q-quantile over the last window_length samples, linearly interpolated
// between neighboring order statistics (index q*(len-1) in Q16). The window is
// kept sorted in a single-port store that one compare/shift unit updates per
// beat: the evicted sample is dropped and the new one slid into place in a
// single walk over the store, one entry per cycle. The walk and the index and
// interpolation multiplies, which share one 17xSAMPLE_BITS multiplier, set how
// long a normal input beat takes. The first beat after any window_length write,
// unless it is a restart, rebuilds the sorted store from the ring by repeated
// insertion. s_tready is high only while the sequencer is idle; a finished
// result sits in the output register and does not hold off the next beat
// until the following result is due. A restart beat empties the window first.
// Registers: window_length at 0x0 (clamped to 1..WINDOW_MAX), quantile_frac
// at 0x4 (Q16, clamped to 65536).

module moving_quantile_filter #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
    input  wire                                   s_tuser,   // restart
    // result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // quantile_value
    // configuration
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [2:0]                            paddr,
    input  wire  [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    import mqf_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = AW + 1;
    localparam int SB = SAMPLE_BITS;
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int EW = (CW > WLEN_BITS) ? CW : WLEN_BITS;
    localparam int PW = QF_BITS + SAMPLE_BITS;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EVICT   = 4'd1;
    localparam logic [3:0] ST_GROW    = 4'd2;
    localparam logic [3:0] ST_RB_READ = 4'd3;
    localparam logic [3:0] ST_RB_WAIT = 4'd4;
    localparam logic [3:0] ST_PASS    = 4'd5;
    localparam logic [3:0] ST_MUL     = 4'd6;
    localparam logic [3:0] ST_RD0     = 4'd7;
    localparam logic [3:0] ST_RD1     = 4'd8;
    localparam logic [3:0] ST_DIFF    = 4'd9;
    localparam logic [3:0] ST_MUL2    = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;

    // (ptr - steps) modulo WINDOW_MAX, steps <= WINDOW_MAX
    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] ptr,
                                                input logic [CW-1:0] steps);
        logic [CW-1:0] diff;
        diff = {1'b0, ptr} - steps;
        if (diff[CW-1]) begin
            diff = diff + CW'(WINDOW_MAX);
        end
        return diff[AW-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [WLEN_BITS-1:0] wl_reg, wl_next;
    logic [QF_BITS-1:0]   q_reg, q_next;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_QUANTILE_FRAC) ? 32'(q_reg) : 32'(wl_reg);

    // ---------------- sequencer state ----------------
    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         wp_reg, wp_next;          // next ring slot to write
    logic [CW-1:0]         fill_reg, fill_next;      // samples held since restart
    logic [CW-1:0]         len_reg, len_next;        // length the sorted store holds
    logic [CW-1:0]         base_len_reg, base_len_next;
    logic [CW-1:0]         k_reg, k_next;            // rebuild insertion count
    logic                  dirty_reg, dirty_next;    // window_length changed
    logic                  rb_reg, rb_next;          // this beat rebuilds
    logic [SB-1:0]         sample_reg, sample_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [SB-1:0]         w0_reg, w0_next;
    logic [SB-1:0]         diff_reg, diff_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SB-1:0]         quantile_reg, quantile_next;

    // ---------------- ring buffer (arrival order) ----------------
    logic [SB-1:0]         ring_mem [WINDOW_MAX];
    logic [SB-1:0]         ring_rdata_reg;
    logic [AW-1:0]         ring_raddr;
    logic                  ring_we;
    logic [AW-1:0]         ring_waddr;

    // ---------------- sort unit hookup ----------------
    mqf_pass_ctl_t         pass_ctl;
    logic [CW-1:0]         pass_count;
    logic [SB-1:0]         pass_value;
    logic [AW-1:0]         sort_raddr;
    logic [SB-1:0]         sort_rdata;
    logic                  pass_done;

    // ---------------- datapath helpers ----------------
    logic                  accept;
    logic                  restart;
    logic [AW-1:0]         wp_eff;
    logic [CW-1:0]         fill_eff;
    logic [CW-1:0]         fill_new;
    logic [EW-1:0]         wl_ext;
    logic [CW-1:0]         wl_eff;
    logic [CW-1:0]         len_new;
    logic [QF_BITS-1:0]    q_eff;
    logic [AW-1:0]         len_m1;
    logic [AW-1:0]         i0;
    logic [QFRAC_BITS-1:0] frac;
    logic [QF_BITS-1:0]    mul_a;
    logic [SB-1:0]         mul_b;
    logic [PW-1:0]         mul_p;
    logic [SB-1:0]         res;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign restart  = s_tuser;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(quantile_reg);

    // effective settings, clamped to their legal ranges
    always_comb begin
        wl_ext = EW'(wl_reg);
        if (wl_ext == '0) begin
            wl_eff = CW'(1);
        end else if (wl_ext > EW'(WINDOW_MAX)) begin
            wl_eff = CW'(WINDOW_MAX);
        end else begin
            wl_eff = CW'(wl_ext);
        end
        q_eff = (q_reg > Q_ONE) ? Q_ONE : q_reg;
    end

    // beat acceptance arithmetic
    assign wp_eff   = restart ? '0 : wp_reg;
    assign fill_eff = restart ? '0 : fill_reg;
    assign fill_new = (fill_eff == CW'(WINDOW_MAX)) ? fill_eff : fill_eff + CW'(1);
    assign len_new  = (fill_new < wl_eff) ? fill_new : wl_eff;

    // interpolation index: pos = q*(len-1), i0 = pos >> 16, frac = pos & 0xFFFF
    assign len_m1 = AW'(len_reg - CW'(1));
    assign i0     = prod_reg[QFRAC_BITS +: AW];
    assign frac   = prod_reg[QFRAC_BITS-1:0];
    assign res    = w0_reg + prod_reg[QFRAC_BITS +: SB];

    // shared multiplier
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        base_len_next = base_len_reg;
        k_next        = k_reg;
        dirty_next    = dirty_reg;
        rb_next       = rb_reg;
        sample_next   = sample_reg;
        prod_next     = prod_reg;
        w0_next       = w0_reg;
        diff_next     = diff_reg;
        wl_next       = wl_reg;
        q_next        = q_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        quantile_next = quantile_reg;

        ring_we    = 1'b0;
        ring_waddr = wp_eff;
        ring_raddr = ring_back(wp_eff, len_reg);   // slot leaving the window

        pass_ctl   = '0;
        pass_count = base_len_reg;
        pass_value = sample_reg;
        sort_raddr = i0;

        mul_a = q_eff;
        mul_b = SB'(len_m1);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sample_next   = s_tdata[SB-1:0];
                    ring_we       = 1'b1;
                    wp_next       = (wp_eff == AW'(WINDOW_MAX - 1)) ? '0 : wp_eff + AW'(1);
                    fill_next     = fill_new;
                    len_next      = len_new;
                    base_len_next = restart ? '0 : len_reg;
                    k_next        = '0;
                    dirty_next    = 1'b0;
                    rb_next       = dirty_reg & ~restart;
                    if (dirty_reg && !restart) begin
                        state_next = ST_RB_READ;
                    end else if (restart || len_new != len_reg) begin
                        state_next = ST_GROW;
                    end else begin
                        state_next = ST_EVICT;
                    end
                end
            end
            ST_EVICT: begin
                // ring read data holds the evicted sample
                pass_ctl.start   = 1'b1;
                pass_ctl.seek    = 1'b1;
                pass_ctl.descend = $signed(sample_reg) < $signed(ring_rdata_reg);
                pass_count       = len_reg;
                state_next       = ST_PASS;
            end
            ST_GROW: begin
                pass_ctl.start   = 1'b1;
                pass_ctl.descend = 1'b1;
                state_next       = ST_PASS;
            end
            ST_RB_READ: begin
                ring_raddr = ring_back(wp_reg, k_reg + CW'(1));
                state_next = ST_RB_WAIT;
            end
            ST_RB_WAIT: begin
                pass_ctl.start   = 1'b1;
                pass_ctl.descend = 1'b1;
                pass_count       = k_reg;
                pass_value       = ring_rdata_reg;
                state_next       = ST_PASS;
            end
            ST_PASS: begin
                if (pass_done) begin
                    if (rb_reg && (k_reg + CW'(1) != len_reg)) begin
                        k_next     = k_reg + CW'(1);
                        state_next = ST_RB_READ;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                state_next = ST_RD1;
            end
            ST_RD1: begin
                // upper neighbor only matters when the fraction is nonzero
                sort_raddr = (frac == '0) ? i0 : i0 + AW'(1);
                w0_next    = sort_rdata;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                diff_next  = sort_rdata - w0_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                mul_a      = QF_BITS'(frac);
                mul_b      = diff_reg;
                prod_next  = mul_p;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    quantile_next = res;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            if (paddr[2] == REG_WINDOW_LENGTH) begin
                wl_next    = pwdata[WLEN_BITS-1:0];
                dirty_next = 1'b1;
            end else begin
                q_next = pwdata[QF_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= s_tdata[SB-1:0];
        end
        ring_rdata_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            len_reg      <= '0;
            base_len_reg <= '0;
            k_reg        <= '0;
            dirty_reg    <= 1'b0;
            rb_reg       <= 1'b0;
            wl_reg       <= WLEN_BITS'(1);
            q_reg        <= QF_BITS'(32768);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            base_len_reg <= base_len_next;
            k_reg        <= k_next;
            dirty_reg    <= dirty_next;
            rb_reg       <= rb_next;
            wl_reg       <= wl_next;
            q_reg        <= q_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sample_reg   <= sample_next;
        prod_reg     <= prod_next;
        w0_reg       <= w0_next;
        diff_reg     <= diff_next;
        quantile_reg <= quantile_next;
    end

    mqf_sort_unit #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sort (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pass_ctl   (pass_ctl),
        .pass_count (pass_count),
        .pass_value (pass_value),
        .pass_evict (ring_rdata_reg),
        .rd_addr    (sort_raddr),
        .rd_data    (sort_rdata),
        .pass_done  (pass_done)
    );

endmodule

`default_nettype wire

FILE: src/mqf_sort_unit.sv
// Sorted window store with the shared compare/shift unit that updates it.
`default_nettype none

module mqf_sort_unit #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  mqf_pkg::mqf_pass_ctl_t              pass_ctl,
    input  wire  [$clog2(WINDOW_MAX):0]         pass_count,
    input  wire  [SAMPLE_BITS-1:0]              pass_value,
    input  wire  [SAMPLE_BITS-1:0]              pass_evict,
    input  wire  [$clog2(WINDOW_MAX)-1:0]       rd_addr,
    output logic [SAMPLE_BITS-1:0]              rd_data,
    output logic                                pass_done
);

    import mqf_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = AW + 1;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    logic                   busy_reg, busy_next;
    logic                   descend_reg, descend_next;
    logic                   seek_reg, seek_next;
    logic                   dvalid_reg, dvalid_next;
    logic [CW-1:0]          remain_reg, remain_next;
    logic [AW-1:0]          ridx_reg, ridx_next;
    logic [AW-1:0]          didx_reg, didx_next;
    logic [AW-1:0]          end_reg, end_next;
    logic [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [SAMPLE_BITS-1:0] evict_reg, evict_next;

    logic [AW-1:0]          first_addr;
    logic [AW-1:0]          nb_addr;
    logic [AW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic                   a_gt;
    logic                   shift;
    logic                   finish;

    assign rd_data   = rdata_reg;
    assign pass_done = finish;

    always_comb begin
        busy_next    = busy_reg;
        descend_next = descend_reg;
        seek_next    = seek_reg;
        dvalid_next  = 1'b0;
        remain_next  = remain_reg;
        ridx_next    = ridx_reg;
        didx_next    = didx_reg;
        end_next     = end_reg;
        val_next     = val_reg;
        evict_next   = evict_reg;
        mem_raddr    = rd_addr;
        mem_we       = 1'b0;
        mem_waddr    = end_reg;
        mem_wdata    = val_reg;
        finish       = 1'b0;

        first_addr = pass_ctl.descend ? AW'(pass_count - CW'(1)) : '0;
        // neighbor slot that a shifted entry moves into
        nb_addr = descend_reg ? didx_reg + AW'(1) : didx_reg - AW'(1);
        a_gt    = $signed(rdata_reg) > $signed(val_reg);
        shift   = descend_reg ? a_gt : !a_gt;

        if (pass_ctl.start) begin
            busy_next    = 1'b1;
            descend_next = pass_ctl.descend;
            seek_next    = pass_ctl.seek;
            val_next     = pass_value;
            evict_next   = pass_evict;
            end_next     = pass_ctl.descend ? '0 : AW'(pass_count - CW'(1));
            mem_raddr    = first_addr;
            dvalid_next  = (pass_count != '0);
            didx_next    = first_addr;
            remain_next  = (pass_count != '0) ? pass_count - CW'(1) : '0;
            ridx_next    = pass_ctl.descend ? first_addr - AW'(1) : first_addr + AW'(1);
        end else if (busy_reg) begin
            mem_raddr = ridx_reg;
            if (dvalid_reg) begin
                if (seek_reg) begin
                    if (rdata_reg == evict_reg) begin
                        seek_next = 1'b0;
                    end
                end else if (shift) begin
                    mem_we    = 1'b1;
                    mem_waddr = nb_addr;
                    mem_wdata = rdata_reg;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = nb_addr;
                    finish    = 1'b1;
                end
            end else begin
                // ran off the end: new value lands at the far slot
                mem_we = 1'b1;
                finish = 1'b1;
            end
            if (finish) begin
                busy_next = 1'b0;
            end else if (remain_reg != '0) begin
                dvalid_next = 1'b1;
                didx_next   = ridx_reg;
                remain_next = remain_reg - CW'(1);
                ridx_next   = descend_reg ? ridx_reg - AW'(1) : ridx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            seek_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
            remain_reg <= '0;
        end else begin
            busy_reg   <= busy_next;
            seek_reg   <= seek_next;
            dvalid_reg <= dvalid_next;
            remain_reg <= remain_next;
        end
        descend_reg <= descend_next;
        ridx_reg    <= ridx_next;
        didx_reg    <= didx_next;
        end_reg     <= end_next;
        val_reg     <= val_next;
        evict_reg   <= evict_next;
    end

endmodule

`default_nettype wire

FILE: tb/mqf_checker.sv
// Scoreboard for the moving quantile filter: watches both streams and the APB port.
module mqf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tuser,   // restart
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // quantile_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mqf_pkg::*;

    localparam int DEPTH = 64;

    logic signed [15:0]   history [DEPTH];
    int                   held;
    int                   next_slot;
    logic [WLEN_BITS-1:0] win_len_reg;
    logic [QF_BITS-1:0]   qfrac_reg;
    logic [15:0]          quantile_q [$];
    int                   fail_n;
    int                   result_n;

    // Store the sample, sort the newest len samples, interpolate at q*(len-1).
    function automatic logic [15:0] push_sample(input logic signed [15:0] smp, input logic rst);
        int                 wl;
        int                 len;
        int                 slot;
        int                 j;
        int                 i0;
        longint unsigned    q;
        longint unsigned    pos;
        longint unsigned    frac;
        longint unsigned    span;
        longint             res;
        logic signed [15:0] win [DEPTH];
        logic signed [15:0] v;
        if (rst) begin
            held      = 0;
            next_slot = 0;
        end
        history[next_slot] = smp;
        next_slot = (next_slot + 1) % DEPTH;
        if (held < DEPTH) held++;
        wl = int'(win_len_reg);
        if (wl < 1) wl = 1;
        if (wl > DEPTH) wl = DEPTH;
        q = longint'(qfrac_reg);
        if (q > longint'(Q_ONE)) q = longint'(Q_ONE);
        len  = (held < wl) ? held : wl;
        slot = next_slot;
        for (int k = 0; k < len; k++) begin
            slot = (slot == 0) ? DEPTH - 1 : slot - 1;
            v = history[slot];
            j = k;
            while (j > 0 && win[j-1] > v) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = v;
        end
        pos  = q * longint'(len - 1);
        i0   = int'(pos >> 16);
        frac = pos & 64'hFFFF;
        if (i0 >= len) i0 = len - 1;
        if (frac == 0 || i0 + 1 >= len) begin
            res = longint'(win[i0]);
        end else begin
            span = longint'(win[i0+1]) - longint'(win[i0]);
            res  = longint'(win[i0]) + longint'((frac * span) >> 16);
        end
        return res[15:0];
    endfunction

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            held        = 0;
            next_slot   = 0;
            win_len_reg = WLEN_BITS'(1);
            qfrac_reg   = Q_ONE >> 1;
            fail_n      = 0;
            result_n    = 0;
            quantile_q.delete();
        end else begin
            // result side first: a beat can leave and another enter on one edge
            if (m_tvalid && m_tready) begin
                result_n++;
                if (quantile_q.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, expected none, actual %0d",
                             $time, $signed(m_tdata));
                    fail_n++;
                end else begin
                    want = quantile_q.pop_front();
                    if (want !== m_tdata) begin
                        $display("%0t ns: quantile_value mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_tdata));
                        fail_n++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_WINDOW_LENGTH) win_len_reg = pwdata[WLEN_BITS-1:0];
                else                               qfrac_reg   = pwdata[QF_BITS-1:0];
            end
            if (s_tvalid && s_tready)
                quantile_q.push_back(push_sample(s_tdata, s_tuser));
        end
        fail_count   <= fail_n;
        pending      <= quantile_q.size();
        result_count <= result_n;
    end

endmodule

FILE: tb/testbench.sv
// Top of the moving quantile filter testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mqf_pkg::*;

    // No beat for this many cycles means the block hung. The slowest legal gap
    // is a full 64-sample rebuild behind the long receiver
    // hold-off, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 800;    // long receiver hold-off
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 50;
    localparam int QUIET_PHASE  = 3;      // no idling on either side
    localparam int STALL_PHASE  = 6;      // receiver holds off, sender keeps pushing

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;           // sample
    logic        s_tuser  = 1'b0;         // restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;                 // quantile_value
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int result_count;

    bit quiet       = 1'b0;  // set for the phase that runs with no idling
    int hold_req    = 0;     // bumped by stimulus to ask for one long hold-off
    int hold_served = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int sent_beats  = 0;
    int reg_writes  = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    moving_quantile_filter #(
        .WINDOW_MAX  (64),
        .SAMPLE_BITS (16)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mqf_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // Result side: random back-pressure, none in the quiet phase, and one long
    // hold-off counted here whenever stimulus asks for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_served) begin
            hold_served <= hold_req;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 17);
        end
    end

    // Watchdog: any beat on either stream resets the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else                                                  idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: watchdog, no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // One input beat. Random idle cycles go in front; valid stays up between
    // back-to-back beats so it is never dropped and raised in one step.
    task automatic send_sample(input logic [15:0] smp, input logic rst);
        if (!quiet) begin
            while ($urandom_range(99) < 17) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= rst;
        do @(posedge aclk); while (!s_tready);
        sent_beats++;
    endtask

    // Drain: stop offering, let every result come out, then a few spare cycles.
    // The first edge lets the checker's count see the last accepted beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // APB write: setup phase, access phase, then the bus goes idle
    task automatic reg_write(input logic sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    // Mix of rail values, a narrow band around zero (lots of ties) and full range
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(9))
            0:       return 32'd0;                       // clamps to 1
            1:       return 32'd64;
            2:       return 32'd127;                     // clamps to 64
            3:       return 32'($urandom_range(127));
            default: return 32'($urandom_range(1, 12));  // keep most windows short
        endcase
    endfunction

    function automatic logic [31:0] pick_quantile();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'(Q_ONE);
            2:       return 32'h1FFFF;                   // clamps to 1.0
            3:       return 32'($urandom_range(131071));
            default: return 32'($urandom_range(65536));
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // reset settings: one-sample window, median; rails pass straight through
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b1);
        drain();

        // four-sample window at q = 1.0, window grows from the restart
        reg_write(REG_WINDOW_LENGTH, 32'd4);
        reg_write(REG_QUANTILE_FRAC, 32'(Q_ONE));
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd6, 1'b0);
        drain();

        // q = 0 picks the minimum
        reg_write(REG_QUANTILE_FRAC, 32'd0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        drain();

        // both registers above range: q clamps to 1.0, length to 64, mid-series
        reg_write(REG_QUANTILE_FRAC, 32'h1FFFF);
        reg_write(REG_WINDOW_LENGTH, 32'd127);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'hFEDC, 1'b0);
        drain();

        // length zero acts as one
        reg_write(REG_WINDOW_LENGTH, 32'd0);
        reg_write(REG_QUANTILE_FRAC, 32'd21845);
        send_sample(16'h4000, 1'b0);
        send_sample(16'hC000, 1'b0);
        drain();

        // interpolation across the full span, length grown mid-series
        reg_write(REG_WINDOW_LENGTH, 32'd3);
        reg_write(REG_QUANTILE_FRAC, 32'd43690);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8001, 1'b1);
        drain();

        // --- random part: new settings each phase, no restart at phase start
        // except by chance, so length changes land mid-series too
        for (int ph = 0; ph < PHASES; ph++) begin
            reg_write(REG_WINDOW_LENGTH, pick_length());
            reg_write(REG_QUANTILE_FRAC, pick_quantile());
            quiet = (ph == QUIET_PHASE);
            if (ph == STALL_PHASE) hold_req++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), $urandom_range(24) == 0);
            drain();
            quiet = 1'b0;
        end

        // tail: nothing outstanding, then a spare stretch for stray beats
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Covered %0d sample beats and %0d register writes; %0d results checked.",
                 sent_beats, reg_writes, result_count);
        $display("Window lengths 0..127, quantiles 0..1.0 and above, restarts and one long stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mqf_pkg.sv
src/mqf_sort_unit.sv
src/moving_quantile_filter.sv
tb/mqf_checker.sv
tb/testbench.sv
